// File: rtl/core/ctp_pkg.sv
package ctp_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int TOL_W     = 16;
    localparam int RAD_W     = COORD_W - 1;
    localparam int CFG_W     = COORD_W;
    localparam int CFG_IDX_W = 2;

    // Offset from the centre, signed, and its magnitude.
    localparam int DIF_W  = COORD_W + 1;
    localparam int SQ_W   = 2 * DIF_W;
    localparam int R2_W   = 2 * RAD_W;
    localparam int THR_W  = R2_W + 1;
    localparam int ROOT_W = DIF_W;
    localparam int RS_W   = RAD_W + ROOT_W;
    localparam int RSH_W  = RS_W / 2;
    localparam int NUM_W  = RS_W + DIF_W + 1;
    // The quotient is an offset of length about the radius, so it fits easily.
    localparam int QUO_W  = COORD_W + 2;
    localparam int QO_W   = QUO_W + 1;
    localparam int REM_W  = SQ_W + QUO_W;
    localparam int SUM_W  = QUO_W + 3;

    localparam int SQRT_LAT = ROOT_W + 1;
    localparam int DIV_LAT  = QUO_W + 2;
    localparam int PIPE_LAT = 4 + SQRT_LAT + 4 + DIV_LAT + 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 2'd3;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } req_t;

    typedef struct packed {
        logic                      valid_res;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } rsp_t;

endpackage

// File: rtl/core/ctp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ctp_sqrt (
    input  logic                         clk,
    input  logic [ctp_pkg::SQ_W-1:0]     radicand,
    output logic [ctp_pkg::ROOT_W-1:0]   root
);

    localparam int N = ctp_pkg::ROOT_W;

    logic [ctp_pkg::SQ_W-1:0] op_reg  [N+1];
    logic [ctp_pkg::SQ_W-1:0] res_reg [N+1];

    always_ff @(posedge clk)
    begin
        op_reg[0]  <= radicand;
        res_reg[0] <= '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int SH = 2 * (N - 1 - k);
        logic [ctp_pkg::SQ_W-1:0] one;
        logic [ctp_pkg::SQ_W-1:0] trial;
        logic [ctp_pkg::SQ_W-1:0] op_next;
        logic [ctp_pkg::SQ_W-1:0] res_next;

        assign one   = ctp_pkg::SQ_W'(1) << SH;
        assign trial = res_reg[k] + one;

        always_comb
        begin
            if (op_reg[k] >= trial)
            begin
                op_next  = op_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + one;
            end
            else
            begin
                op_next  = op_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[k+1]  <= op_next;
            res_reg[k+1] <= res_next;
        end
    end

    assign root = res_reg[N][ctp_pkg::ROOT_W-1:0];

endmodule

// File: rtl/core/ctp_div.sv
// Pipelined restoring divider with round half up, one quotient bit per stage.
module ctp_div (
    input  logic                        clk,
    input  logic [ctp_pkg::NUM_W-1:0]   num,
    input  logic [ctp_pkg::SQ_W-1:0]    den,
    output logic [ctp_pkg::QO_W-1:0]    quo
);

    localparam int N = ctp_pkg::QUO_W;

    logic [ctp_pkg::REM_W-1:0] rem_reg [N+1];
    logic [ctp_pkg::SQ_W-1:0]  den_reg [N+1];
    logic [N-1:0]              q_reg   [N+1];
    logic [ctp_pkg::QO_W-1:0]  quo_reg;
    logic [ctp_pkg::SQ_W:0]    twice_rem;
    logic                      round_up;

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ctp_pkg::REM_W'(num);
        den_reg[0] <= den;
        q_reg[0]   <= '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam int SH = N - 1 - k;
        logic [ctp_pkg::REM_W-1:0] dsh;
        logic                      take;

        assign dsh  = ctp_pkg::REM_W'(den_reg[k]) << SH;
        assign take = rem_reg[k] >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= take ? rem_reg[k] - dsh : rem_reg[k];
            den_reg[k+1] <= den_reg[k];
            q_reg[k+1]   <= {q_reg[k][N-2:0], take};
        end
    end

    // The remainder is below the divisor here, so its low bits hold it all.
    assign twice_rem = {rem_reg[N][ctp_pkg::SQ_W-1:0], 1'b0};
    assign round_up  = twice_rem >= {1'b0, den_reg[N]};

    always_ff @(posedge clk)
    begin
        quo_reg <= ctp_pkg::QO_W'(q_reg[N]) + ctp_pkg::QO_W'(round_up);
    end

    assign quo = quo_reg;

endmodule

// File: rtl/core/circle_tangent_points.sv
// Tangent points from a query point to a configured circle, in Q16.16.
// A request is taken whenever start is high; busy is always low, so one
// query point may enter in every clock cycle. The answer appears on rsp,
// with done high for exactly one cycle; the latency is set mainly by
// the 33-stage square root and the 34-stage dividers, and the receiver
// cannot hold results back.
// The first point is the one with the larger x, then the larger y; when
// the point lies within the tolerance of the circle or inside it,
// valid_res is 0 and all coordinates are 0. Coordinates saturate.
// Configuration (centre, radius, tolerance) may only be written while no
// request is in flight.
module circle_tangent_points (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ctp_pkg::req_t                    req,
    output logic                             done,
    output ctp_pkg::rsp_t                    rsp,
    input  logic                             cfg_we,
    input  logic [ctp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctp_pkg::CFG_W-1:0]        cfg_data
);

    localparam int C  = ctp_pkg::COORD_W;
    localparam int DW = ctp_pkg::DIF_W;

    // Side data that rides along with the square root.
    typedef struct packed {
        logic                      ok;
        logic [ctp_pkg::SQ_W-1:0]  d2;
        logic [DW-1:0]             ax;
        logic [DW-1:0]             ay;
        logic                      xn;
        logic                      yn;
    } sq_band_t;

    // Side data that rides along with the dividers.
    typedef struct packed {
        logic                      ok;
        logic [3:0]                neg;
    } dv_band_t;

    //------------------------------------------------------------------
    // Configuration registers, plus the squared radius and threshold
    // derived from them in registers.
    //------------------------------------------------------------------
    logic signed [C-1:0]            cx_reg;
    logic signed [C-1:0]            cy_reg;
    logic [ctp_pkg::RAD_W-1:0]      rad_reg;
    logic [ctp_pkg::TOL_W-1:0]      tol_reg;
    logic [ctp_pkg::R2_W-1:0]       r2_reg;
    logic [ctp_pkg::THR_W-1:0]      thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            rad_reg <= '0;
            tol_reg <= ctp_pkg::TOL_RESET;
            r2_reg  <= '0;
            thr_reg <= ctp_pkg::THR_W'(ctp_pkg::TOL_RESET) << ctp_pkg::FRAC_BITS;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ctp_pkg::REG_CENTER_X: cx_reg  <= cfg_data[C-1:0];
                    ctp_pkg::REG_CENTER_Y: cy_reg  <= cfg_data[C-1:0];
                    ctp_pkg::REG_RADIUS:   rad_reg <= cfg_data[ctp_pkg::RAD_W-1:0];
                    ctp_pkg::REG_TOL:      tol_reg <= cfg_data[ctp_pkg::TOL_W-1:0];
                    default:               ;
                endcase
            end
            r2_reg  <= ctp_pkg::R2_W'(rad_reg) * ctp_pkg::R2_W'(rad_reg);
            thr_reg <= ctp_pkg::THR_W'(r2_reg)
                     + (ctp_pkg::THR_W'(tol_reg) << ctp_pkg::FRAC_BITS);
        end
    end

    assign busy = 1'b0;

    //------------------------------------------------------------------
    // Stage 1: offsets from the centre. Stage 2: magnitudes and signs.
    //------------------------------------------------------------------
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0]  x1_reg, y1_reg;
    logic [DW-1:0]         ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic                  xn2_reg, yn2_reg, xn3_reg, yn3_reg;
    logic [ctp_pkg::SQ_W-1:0] axx3_reg, ayy3_reg;
    sq_band_t              b4_reg;
    logic [ctp_pkg::SQ_W-1:0] disc4_reg;
    logic [ctp_pkg::SQ_W-1:0] d2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign d2_next = axx3_reg + ayy3_reg;

    always_ff @(posedge clk)
    begin
        x1_reg  <= DW'(req.px) - DW'(cx_reg);
        y1_reg  <= DW'(req.py) - DW'(cy_reg);

        ax2_reg <= x1_reg[DW-1] ? DW'(-x1_reg) : DW'(x1_reg);
        ay2_reg <= y1_reg[DW-1] ? DW'(-y1_reg) : DW'(y1_reg);
        xn2_reg <= x1_reg[DW-1];
        yn2_reg <= y1_reg[DW-1];

        axx3_reg <= ctp_pkg::SQ_W'(ax2_reg) * ctp_pkg::SQ_W'(ax2_reg);
        ayy3_reg <= ctp_pkg::SQ_W'(ay2_reg) * ctp_pkg::SQ_W'(ay2_reg);
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        xn3_reg  <= xn2_reg;
        yn3_reg  <= yn2_reg;

        // Stage 4: squared distance, validity and discriminant.
        b4_reg.ok <= (ctp_pkg::SQ_W+1)'(d2_next) > (ctp_pkg::SQ_W+1)'(thr_reg);
        b4_reg.d2 <= d2_next;
        b4_reg.ax <= ax3_reg;
        b4_reg.ay <= ay3_reg;
        b4_reg.xn <= xn3_reg;
        b4_reg.yn <= yn3_reg;
        disc4_reg <= d2_next - ctp_pkg::SQ_W'(r2_reg);
    end

    //------------------------------------------------------------------
    // Square root of the discriminant, side data delayed alongside.
    //------------------------------------------------------------------
    logic [ctp_pkg::ROOT_W-1:0] root;
    logic     sqv_reg [ctp_pkg::SQRT_LAT];
    sq_band_t sqb_reg [ctp_pkg::SQRT_LAT];

    ctp_sqrt u_sqrt (
        .clk      (clk),
        .radicand (disc4_reg),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctp_pkg::SQRT_LAT; i++)
            begin
                sqv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sqv_reg[0] <= v4_reg;
            for (int i = 1; i < ctp_pkg::SQRT_LAT; i++)
            begin
                sqv_reg[i] <= sqv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sqb_reg[0] <= b4_reg;
        for (int i = 1; i < ctp_pkg::SQRT_LAT; i++)
        begin
            sqb_reg[i] <= sqb_reg[i-1];
        end
    end

    //------------------------------------------------------------------
    // Stage 5: r*s. Stage 6: half-width partial products.
    // Stage 7: full products. Stage 8: signed sums as sign and magnitude.
    //------------------------------------------------------------------
    localparam int RH = ctp_pkg::RAD_W;
    localparam int SH = ctp_pkg::RSH_W;

    logic                       v5_reg, v6_reg, v7_reg, v8_reg;
    sq_band_t                   b5_reg, b6_reg, b7_reg;
    logic [ctp_pkg::RS_W-1:0]   rs5_reg;
    logic [RH+DW-1:0]           rxl_reg, rxh_reg, ryl_reg, ryh_reg;
    logic [SH+DW-1:0]           sxl_reg, sxh_reg, syl_reg, syh_reg;
    logic [ctp_pkg::NUM_W-1:0]  rx7_reg, ry7_reg, sx7_reg, sy7_reg;
    logic [ctp_pkg::NUM_W-1:0]  mag8_reg [4];
    dv_band_t                   b8_reg;
    logic [ctp_pkg::SQ_W-1:0]   d8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= sqv_reg[ctp_pkg::SQRT_LAT-1];
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    // Combine two terms with signs: the larger magnitude sets the sign.
    function automatic logic [ctp_pkg::NUM_W:0] signed_sum(
        input logic [ctp_pkg::NUM_W-1:0] a,
        input logic                      an,
        input logic [ctp_pkg::NUM_W-1:0] b,
        input logic                      bn
    );
        logic [ctp_pkg::NUM_W-1:0] mag;
        logic                      neg;
        if (an == bn)
        begin
            mag = a + b;
            neg = an;
        end
        else if (a >= b)
        begin
            mag = a - b;
            neg = an;
        end
        else
        begin
            mag = b - a;
            neg = bn;
        end
        return {neg, mag};
    endfunction

    logic [ctp_pkg::NUM_W:0] t0x, t0y, t1x, t1y;

    assign t0x = signed_sum(rx7_reg, b7_reg.xn, sy7_reg, !b7_reg.yn);
    assign t0y = signed_sum(ry7_reg, b7_reg.yn, sx7_reg, b7_reg.xn);
    assign t1x = signed_sum(rx7_reg, b7_reg.xn, sy7_reg, b7_reg.yn);
    assign t1y = signed_sum(ry7_reg, b7_reg.yn, sx7_reg, !b7_reg.xn);

    always_ff @(posedge clk)
    begin
        b5_reg  <= sqb_reg[ctp_pkg::SQRT_LAT-1];
        rs5_reg <= ctp_pkg::RS_W'(rad_reg) * ctp_pkg::RS_W'(root);

        b6_reg  <= b5_reg;
        rxl_reg <= (RH+DW)'(r2_reg[RH-1:0]) * (RH+DW)'(b5_reg.ax);
        rxh_reg <= (RH+DW)'(r2_reg[ctp_pkg::R2_W-1:RH]) * (RH+DW)'(b5_reg.ax);
        ryl_reg <= (RH+DW)'(r2_reg[RH-1:0]) * (RH+DW)'(b5_reg.ay);
        ryh_reg <= (RH+DW)'(r2_reg[ctp_pkg::R2_W-1:RH]) * (RH+DW)'(b5_reg.ay);
        sxl_reg <= (SH+DW)'(rs5_reg[SH-1:0]) * (SH+DW)'(b5_reg.ax);
        sxh_reg <= (SH+DW)'(rs5_reg[ctp_pkg::RS_W-1:SH]) * (SH+DW)'(b5_reg.ax);
        syl_reg <= (SH+DW)'(rs5_reg[SH-1:0]) * (SH+DW)'(b5_reg.ay);
        syh_reg <= (SH+DW)'(rs5_reg[ctp_pkg::RS_W-1:SH]) * (SH+DW)'(b5_reg.ay);

        b7_reg  <= b6_reg;
        rx7_reg <= (ctp_pkg::NUM_W'(rxh_reg) << RH) + ctp_pkg::NUM_W'(rxl_reg);
        ry7_reg <= (ctp_pkg::NUM_W'(ryh_reg) << RH) + ctp_pkg::NUM_W'(ryl_reg);
        sx7_reg <= (ctp_pkg::NUM_W'(sxh_reg) << SH) + ctp_pkg::NUM_W'(sxl_reg);
        sy7_reg <= (ctp_pkg::NUM_W'(syh_reg) << SH) + ctp_pkg::NUM_W'(syl_reg);

        mag8_reg[0] <= t0x[ctp_pkg::NUM_W-1:0];
        mag8_reg[1] <= t0y[ctp_pkg::NUM_W-1:0];
        mag8_reg[2] <= t1x[ctp_pkg::NUM_W-1:0];
        mag8_reg[3] <= t1y[ctp_pkg::NUM_W-1:0];
        b8_reg.neg  <= {t1y[ctp_pkg::NUM_W], t1x[ctp_pkg::NUM_W],
                        t0y[ctp_pkg::NUM_W], t0x[ctp_pkg::NUM_W]};
        b8_reg.ok   <= b7_reg.ok;
        d8_reg      <= b7_reg.d2;
    end

    //------------------------------------------------------------------
    // Four dividers by the squared distance, one per coordinate.
    //------------------------------------------------------------------
    logic [ctp_pkg::QO_W-1:0] quo [4];
    logic     dvv_reg [ctp_pkg::DIV_LAT];
    dv_band_t dvb_reg [ctp_pkg::DIV_LAT];

    for (genvar j = 0; j < 4; j++) begin : g_div
        ctp_div u_div (
            .clk (clk),
            .num (mag8_reg[j]),
            .den (d8_reg),
            .quo (quo[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ctp_pkg::DIV_LAT; i++)
            begin
                dvv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            dvv_reg[0] <= v8_reg;
            for (int i = 1; i < ctp_pkg::DIV_LAT; i++)
            begin
                dvv_reg[i] <= dvv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvb_reg[0] <= b8_reg;
        for (int i = 1; i < ctp_pkg::DIV_LAT; i++)
        begin
            dvb_reg[i] <= dvb_reg[i-1];
        end
    end

    //------------------------------------------------------------------
    // Stage 9: add the centre back and saturate.
    // Stage 10: order the two points and register the response.
    //------------------------------------------------------------------
    function automatic logic [C-1:0] place(
        input logic signed [C-1:0]       c,
        input logic [ctp_pkg::QO_W-1:0]  q,
        input logic                      neg
    );
        logic signed [ctp_pkg::SUM_W-1:0] sum;
        logic [ctp_pkg::SUM_W-C:0]        top;
        sum = neg ? ctp_pkg::SUM_W'(c) - ctp_pkg::SUM_W'(q)
                  : ctp_pkg::SUM_W'(c) + ctp_pkg::SUM_W'(q);
        top = sum[ctp_pkg::SUM_W-1:C-1];
        if (&top || ~|top)
        begin
            return sum[C-1:0];
        end
        return sum[ctp_pkg::SUM_W-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
    endfunction

    logic                v9_reg;
    logic                ok9_reg;
    logic signed [C-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    dv_band_t            bd;
    logic                swap;
    ctp_pkg::rsp_t       rsp_reg;
    logic                done_reg;

    assign bd   = dvb_reg[ctp_pkg::DIV_LAT-1];
    assign swap = (p1x_reg > p0x_reg) || ((p1x_reg == p0x_reg) && (p1y_reg > p0y_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v9_reg   <= dvv_reg[ctp_pkg::DIV_LAT-1];
            done_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok9_reg <= bd.ok;
        p0x_reg <= place(cx_reg, quo[0], bd.neg[0]);
        p0y_reg <= place(cy_reg, quo[1], bd.neg[1]);
        p1x_reg <= place(cx_reg, quo[2], bd.neg[2]);
        p1y_reg <= place(cy_reg, quo[3], bd.neg[3]);

        if (!ok9_reg)
        begin
            rsp_reg <= '0;
        end
        else
        begin
            rsp_reg.valid_res <= 1'b1;
            rsp_reg.first_x   <= swap ? p1x_reg : p0x_reg;
            rsp_reg.first_y   <= swap ? p1y_reg : p0y_reg;
            rsp_reg.second_x  <= swap ? p0x_reg : p1x_reg;
            rsp_reg.second_y  <= swap ? p0y_reg : p1y_reg;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/core/ctp_checker.sv
// Port-level checks on the tangent point block.
module ctp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ctp_pkg::rsp_t rsp
);

    // Every response has a request taken the pipeline latency earlier.
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ctp_pkg::PIPE_LAT))
        else $error("response without matching request");

    // An invalid response carries all-zero coordinates.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.valid_res) |->
            (rsp.first_x == 0 && rsp.first_y == 0 &&
             rsp.second_x == 0 && rsp.second_y == 0))
        else $error("invalid response with nonzero coordinates");

    // The first point never has a smaller x than the second.
    a_order_x: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.valid_res) |-> (rsp.first_x >= rsp.second_x))
        else $error("tangent points out of order in x");

    // On equal x, the first point has the larger or equal y.
    a_order_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.valid_res && rsp.first_x == rsp.second_x) |->
            (rsp.first_y >= rsp.second_y))
        else $error("tangent points out of order in y");

endmodule

bind circle_tangent_points ctp_checker u_ctp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
